/* design/mdp_pkg.sv */
// shared types and constants for the modular dot product
package mdp_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned CfgIdxBits = 1;

  typedef enum logic [CfgIdxBits-1:0] {
    RegModulus  = 1'b0,
    RegAccWords = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic take;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
  } dp_sts_t;

endpackage

/* design/mdp_datapath.sv */
// multiplier pipeline, multiword accumulator and bit-serial reducer
module mdp_datapath #(
  parameter int unsigned ElemBits    = 64,
  parameter int unsigned MaxAccWords = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ElemBits-1:0]           elem_a_i,
  input  logic [ElemBits-1:0]           elem_b_i,
  input  logic                          in_fire_i,
  input  logic [mdp_pkg::WordBits-1:0]  modulus_i,
  input  logic [1:0]                    acc_words_i,
  input  mdp_pkg::dp_cmd_t              cmd_i,
  output mdp_pkg::dp_sts_t              sts_o,
  output logic [mdp_pkg::WordBits-1:0]  residue_o,
  output logic                          mul_busy_o
);

  localparam int unsigned W = mdp_pkg::WordBits;
  localparam int unsigned AccBits = W * MaxAccWords;
  localparam int unsigned HalfBits = (ElemBits + 1) / 2;
  localparam int unsigned PartBits = 2 * HalfBits;
  localparam int unsigned ProdBits = 2 * ElemBits;
  localparam int unsigned CntBits = $clog2(AccBits + 1);

  // stage 1: four partial products
  logic [PartBits-1:0] pll_q, plh_q, phl_q, phh_q;
  logic                v1_q, v2_q;
  logic [HalfBits-1:0] al, ah, bl, bh;
  logic [ProdBits-1:0] prod_d, prod_q;
  logic [AccBits-1:0]  acc_q, acc_d, prod_ext, red_src, red_d, red_q;
  logic [W-1:0]        rem_q, rem_d, r2, mod_q;
  logic                top;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [1:0]          words;
  logic                zero_w, zero_w_q, mod_zero_q;

  assign al = HalfBits'(elem_a_i);
  assign ah = HalfBits'({{PartBits{1'b0}}, elem_a_i} >> HalfBits);
  assign bl = HalfBits'(elem_b_i);
  assign bh = HalfBits'({{PartBits{1'b0}}, elem_b_i} >> HalfBits);

  always_ff @(posedge clk_i) begin
    pll_q <= al * bl;
    plh_q <= al * bh;
    phl_q <= ah * bl;
    phh_q <= ah * bh;
  end

  always_comb begin
    logic [2*PartBits+1:0] sum;
    sum = (2*PartBits+2)'(pll_q)
        + ((2*PartBits+2)'(plh_q) << HalfBits)
        + ((2*PartBits+2)'(phl_q) << HalfBits)
        + ((2*PartBits+2)'(phh_q) << (2*HalfBits));
    prod_d = ProdBits'(sum);
  end

  always_ff @(posedge clk_i) prod_q <= prod_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_fire_i;
      v2_q <= v1_q;
    end
  end

  assign mul_busy_o = v1_q | v2_q;

  if (ProdBits >= AccBits) begin : g_trunc
    assign prod_ext = AccBits'(prod_q);
  end else begin : g_ext
    assign prod_ext = {{(AccBits-ProdBits){1'b0}}, prod_q};
  end

  assign words = (acc_words_i > 2'(MaxAccWords)) ? 2'(MaxAccWords) : acc_words_i;
  assign zero_w = (words == 2'd0);

  always_comb begin
    acc_d = acc_q;
    if (v2_q) acc_d = acc_q + prod_ext;
    if (cmd_i.clear) acc_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else         acc_q <= acc_d;
  end

  always_comb begin
    red_src = '0;
    for (int i = 0; i < MaxAccWords; i++) begin
      if (i < int'(words)) red_src[i*W +: W] = acc_q[i*W +: W];
    end
  end

  // one bit of restoring reduction per cycle while step is asserted, msb first
  assign top = rem_q[W-1];
  assign r2  = {rem_q[W-2:0], red_q[AccBits-1]};

  always_comb begin
    red_d = red_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      red_d = red_src;
      rem_d = '0;
      cnt_d = CntBits'(AccBits);
    end else if (cmd_i.step) begin
      red_d = red_q << 1;
      rem_d = (top || r2 >= mod_q) ? r2 - mod_q : r2;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      mod_q      <= modulus_i;
      mod_zero_q <= (modulus_i == '0);
      zero_w_q   <= zero_w;
      residue_o  <= red_src[W-1:0];
    end else if (cmd_i.take) begin
      if (zero_w_q)        residue_o <= '0;
      else if (!mod_zero_q) residue_o <= rem_q;
    end
  end

  assign sts_o.red_done = (cnt_q == '0);

endmodule

/* design/mdp_ctrl.sv */
// sequencing of accumulate, reduce and result hand-off
module mdp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid,
  input  logic             in_last_i,
  output logic             in_ready,
  input  logic             mul_busy_i,
  output logic             out_valid,
  input  logic             out_ready,
  output mdp_pkg::dp_cmd_t cmd_o,
  input  mdp_pkg::dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    StAcc, StDrain, StLoad, StRed, StTake, StOut
  } state_e;

  state_e state_q;

  assign in_ready = (state_q == StAcc);

  always_comb begin
    cmd_o = '0;
    cmd_o.load  = (state_q == StLoad);
    cmd_o.step  = (state_q == StRed) && !sts_i.red_done;
    cmd_o.take  = (state_q == StTake);
    cmd_o.clear = (state_q == StTake);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StAcc;
      out_valid <= 1'b0;
    end else begin
      case (state_q)
        StAcc:   if (in_valid && in_last_i) state_q <= StDrain;
        StDrain: if (!mul_busy_i) state_q <= StLoad;
        StLoad:  state_q <= StRed;
        StRed:   if (sts_i.red_done) state_q <= StTake;
        StTake: begin
          state_q   <= StOut;
          out_valid <= 1'b1;
        end
        StOut: if (out_ready) begin
          state_q   <= StAcc;
          out_valid <= 1'b0;
        end
        default: state_q <= StAcc;
      endcase
    end
  end

endmodule

/* design/modular_dot_product.sv */
// top level of the modular dot product
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | elem_a_i, elem_b_i, last_i
//   out     | output    | out_valid / out_ready  | residue_o
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index_i, cfg_data_i
// one pair a cycle within a vector; the two-stage multiplier feeds the accumulator
// the last pair is followed by a drain state until the multiplier is empty, a load
// state, bit-serial reduction with one accumulator bit a cycle and a hand-off state;
// the result beat is offered after the hand-off state
// input is held off from the last beat until its result beat is taken
// reset: modulus 1, three words, accumulator zero
module modular_dot_product #(
  parameter int unsigned ELEM_BITS     = 64,
  parameter int unsigned MAX_ACC_WORDS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ELEM_BITS-1:0]          elem_a_i,
  input  logic [ELEM_BITS-1:0]          elem_b_i,
  input  logic                          last_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mdp_pkg::WordBits-1:0]  residue_o,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mdp_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [mdp_pkg::WordBits-1:0]  cfg_data_i
);

  logic [mdp_pkg::WordBits-1:0] modulus_q;
  logic [1:0]                   acc_words_q;
  mdp_pkg::dp_cmd_t             cmd;
  mdp_pkg::dp_sts_t             sts;
  logic                         mul_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= mdp_pkg::WordBits'(1);
      acc_words_q <= 2'd3;
    end else if (cfg_valid) begin
      case (mdp_pkg::cfg_reg_e'(cfg_index_i))
        mdp_pkg::RegModulus:  modulus_q   <= cfg_data_i;
        mdp_pkg::RegAccWords: acc_words_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  mdp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid, .in_last_i(last_i), .in_ready,
    .mul_busy_i(mul_busy),
    .out_valid, .out_ready,
    .cmd_o(cmd), .sts_i(sts)
  );

  mdp_datapath #(.ElemBits(ELEM_BITS), .MaxAccWords(MAX_ACC_WORDS)) u_dp (
    .clk_i, .rst_ni,
    .elem_a_i, .elem_b_i,
    .in_fire_i(in_valid && in_ready),
    .modulus_i(modulus_q),
    .acc_words_i(acc_words_q),
    .cmd_i(cmd), .sts_o(sts),
    .residue_o, .mul_busy_o(mul_busy)
  );

endmodule

/* design/mdp_checker.sv */
// port-level checks for the modular dot product
module mdp_port_checks (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic last_i,
  input logic out_valid,
  input logic out_ready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && last_i |=> !in_ready) else $error("input open after last beat");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> !out_valid) else $error("result beat repeated");

endmodule

bind modular_dot_product mdp_port_checks u_mdp_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .last_i, .out_valid, .out_ready
);

/* tb/mdp_checker.sv */
// checker for the modular dot product: tracks config, predicts residues, compares result beats
`timescale 1ns / 100ps
module mdp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [63:0]                    elem_a_i,
  input  logic [63:0]                    elem_b_i,
  input  logic                           last_i,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [63:0]                    residue_o,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mdp_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  output int                             fail_count_o,
  output int                             pending_o
);

  logic [63:0]  mod_q;
  logic [1:0]   words_q;
  logic [191:0] dot_acc;
  logic [63:0]  residue_q[$];
  int           fails;

  assign fail_count_o = fails;
  assign pending_o    = residue_q.size();

  function automatic logic [63:0] predict_residue(logic [191:0] acc, logic [1:0] w,
                                                  logic [63:0] n);
    logic [191:0] cut;
    cut = acc;
    if (w < 2'd3) cut[191:128] = '0;
    if (w < 2'd2) cut[127:64]  = '0;
    if (w == 2'd0) return '0;
    if (n == '0) return cut[63:0];
    return 64'(cut % {128'd0, n});
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [191:0] sum;
    logic [63:0]  want;
    if (!rst_ni) begin
      mod_q   = 64'd1;
      words_q = 2'd3;
      dot_acc = '0;
      fails   = 0;
      residue_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mdp_pkg::RegModulus) mod_q = cfg_data;
        else words_q = cfg_data[1:0];
      end
      if (in_valid && in_ready) begin
        sum = dot_acc + {64'd0, 128'(elem_a_i) * 128'(elem_b_i)};
        if (last_i) begin
          residue_q.push_back(predict_residue(sum, words_q, mod_q));
          dot_acc = '0;
        end else begin
          dot_acc = sum;
        end
      end
      if (out_valid && out_ready) begin
        if (residue_q.size() == 0) begin
          report_mismatch("unexpected beat", residue_o, '0);
        end else begin
          want = residue_q.pop_front();
          if (residue_o !== want) report_mismatch("residue", residue_o, want);
        end
      end
    end
  end
endmodule

/* tb/tb_modular_dot_product.sv */
// testbench top for the modular dot product: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
module tb_modular_dot_product;

  localparam int unsigned DrainCycles = 240;
  localparam int unsigned StallLimit  = 20000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [63:0]                    elem_a_i = '0;
  logic [63:0]                    elem_b_i = '0;
  logic                           last_i = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [63:0]                    residue_o;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mdp_pkg::CfgIdxBits-1:0] cfg_index_i = mdp_pkg::RegModulus;
  logic [63:0]                    cfg_data_i = '0;

  int fail_count, pending, idle_pct, items_sent, vectors_sent, cfg_writes;
  int stall_cycles = 0;
  logic [63:0] cur_mod;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  modular_dot_product dut (.*);

  mdp_checker u_checker (
    .clk_i, .rst_ni, .in_valid, .in_ready, .elem_a_i, .elem_b_i, .last_i,
    .out_valid, .out_ready, .residue_o, .cfg_valid, .cfg_ready,
    .cfg_index(cfg_index_i), .cfg_data(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("watchdog expired at %0t", $realtime);
      $display("[modular_dot_product] ERROR");
      $finish;
    end
  end

  task automatic send_pair(logic [63:0] a, logic [63:0] b, logic lst);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    in_valid = 1'b1;
    elem_a_i = a;
    elem_b_i = b;
    last_i   = lst;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    in_valid = 1'b0;
    items_sent++;
    if (lst) vectors_sent++;
  endtask

  task automatic write_reg(mdp_pkg::cfg_reg_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid   = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    cfg_writes++;
    if (idx == mdp_pkg::RegModulus) cur_mod = data;
  endtask

  task automatic settle;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_config(logic [63:0] n, logic [63:0] w);
    settle();
    write_reg(mdp_pkg::RegModulus, n);
    write_reg(mdp_pkg::RegAccWords, w);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_elem();
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      2, 3: return rand_word();
      default: return (cur_mod == 0) ? rand_word() : rand_word() % cur_mod;
    endcase
  endfunction

  function automatic logic [63:0] rand_modulus();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      2: return 64'd1;
      3: return 64'($urandom_range(1000, 2));
      4: return {1'b1, 63'(rand_word())};
      default: return rand_word();
    endcase
  endfunction

  initial begin
    int len;
    idle_pct = 25;
    items_sent = 0;
    vectors_sent = 0;
    cfg_writes = 0;
    cur_mod = 64'd1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(negedge clk_i);

    // directed: reset config, then extremes
    send_pair('1, '1, 1'b1);
    set_config('1, 64'd3);
    send_pair('1, '1, 1'b1);
    send_pair('1, '1, 1'b0);
    send_pair('1, '1, 1'b0);
    send_pair('1, '1, 1'b1);
    send_pair('0, '0, 1'b1);
    // modulus zero taken as 2^64
    set_config('0, 64'd2);
    send_pair('1, '1, 1'b0);
    send_pair(64'h8000_0000_0000_0001, '1, 1'b1);
    // width zero gives zero and still clears
    set_config(64'd97, 64'd0);
    send_pair('1, 64'd5, 1'b0);
    send_pair(64'd3, 64'd7, 1'b1);
    set_config(64'd97, 64'd1);
    send_pair(64'd3, 64'd7, 1'b1);
    send_pair('1, '1, 1'b0);
    send_pair('1, '1, 1'b1);
    // elements above modulus, wrap at 128 bits
    set_config(64'd7, 64'd2);
    send_pair('1, '1, 1'b0);
    send_pair('1, '1, 1'b0);
    send_pair(64'd100, 64'd200, 1'b1);
    set_config(64'h7fff_ffff_ffff_ffff, 64'd3);
    send_pair('1, 64'h5555_5555_5555_5555, 1'b0);
    send_pair(64'haaaa_aaaa_aaaa_aaaa, '1, 1'b1);

    // random phases with pressure pauses between them
    for (int ph = 0; items_sent < 1380; ph++) begin
      set_config(rand_modulus(), 64'($urandom_range(3)));
      idle_pct = (ph % 5 == 2) ? 0 : 25;
      for (int v = 0; v < 12; v++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
        for (int k = 1; k <= len; k++) send_pair(rand_elem(), rand_elem(), k == len);
      end
    end

    idle_pct = 25;
    settle();
    $display("covered %0d element pairs in %0d vectors over %0d register writes",
             items_sent, vectors_sent, cfg_writes);
    $display("widths 0..3, modulus zero, one, small, maximum and random, with stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("[modular_dot_product] OK");
    end else begin
      $display("failures %0d, outstanding residues %0d", fail_count, pending);
      $display("[modular_dot_product] ERROR");
    end
    $finish;
  end
endmodule
